### hdl/serial_command_frame_parser_macros.svh
// Assertion helpers shared by the parser RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCFP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scfp assertion failed");

// Next-cycle implication, checked outside reset.
`define SCFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scfp assertion failed");

`endif

### hdl/scfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scfp_pkg;

	// Byte values that frame the packet.
	localparam logic [7:0] HDR_A    = 8'h41;
	localparam logic [7:0] HDR_F    = 8'h46;
	localparam logic [7:0] BCAST    = 8'h30;
	localparam logic [7:0] LETTER_P = 8'h50;
	localparam logic [7:0] LETTER_Z = 8'h5A;

	localparam int unsigned CMD_EN_W  = 26;
	localparam int unsigned PADDR_W   = 3;

	// Register select, taken from paddr bit 2 (registers at byte 0 and byte 4).
	localparam logic REG_OWN_ID = 1'b0;
	localparam logic REG_CMD_EN = 1'b1;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_HDR_F   = 4'd1,
		PH_TARGET  = 4'd2,
		PH_SOURCE  = 4'd3,
		PH_CMD     = 4'd4,
		PH_OPA     = 4'd5,
		PH_OPB_HI  = 4'd6,
		PH_OPB_LO  = 4'd7,
		PH_TRL_F   = 4'd8,
		PH_TRL_A   = 4'd9
	} phase_t;

	// Command letter A to Z other than P, with its enable bit set.
	function automatic logic letter_enabled(input logic [7:0] letter,
			input logic [CMD_EN_W-1:0] enables);
		logic [7:0] offs;
		logic       ok;
		offs = letter - HDR_A;
		ok = (letter >= HDR_A) && (letter <= LETTER_Z) && (letter != LETTER_P);
		return ok && enables[offs[4:0]];
	endfunction

endpackage

`default_nettype wire

### hdl/scfp_channels.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel carrying one received byte per item.
interface scfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Channel carrying one decoded command per item.
interface scfp_cmd_if;
	logic        valid;
	logic        ready;
	logic [7:0]  source_id;
	logic [6:0]  command_letter;
	logic [7:0]  operand_a;
	logic [15:0] operand_b;

	modport source (output valid, output source_id, output command_letter,
		output operand_a, output operand_b, input ready);
	modport sink (input valid, input source_id, input command_letter,
		input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

### hdl/serial_command_frame_parser.sv
// Serial command frame parser.
// The rx channel takes one received byte per item; the cmd channel delivers
// one decoded command (source id, letter, two operands) per valid frame.
// A frame is 'A' 'F' target source letter opA opB_hi opB_lo 'F' 'A'; frames
// for another target (neither own_id nor broadcast '0'), disabled letters,
// the letter P and bad trailers give no item.
// Throughput: one byte per cycle while cmd does not stall. The final
// trailer byte passes through the input register and then the result
// register before its command is offered on cmd.
// Configuration: APB port, own_id at byte address 0, command_enable at 4.
// Write only while the parser is idle; writes apply from the next byte.
// Reset clears the phase to header hunting, both registers to zero and
// empties the pipeline. If cmd stalls, the result register holds its item
// and one further byte is buffered in the input register, after which rx
// ready drops until cmd takes the pending item.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_command_frame_parser_macros.svh"

module serial_command_frame_parser
	import scfp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	scfp_byte_if.sink               rx,
	scfp_cmd_if.source              cmd
);

	logic [7:0]          own_id_q;
	logic [CMD_EN_W-1:0] cmd_en_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	phase_t      phase_q;
	phase_t      phase_nxt;
	logic [7:0]  sender_q;
	logic [7:0]  command_q;
	logic [7:0]  opa_q;
	logic [15:0] opb_q;

	logic ld_sender;
	logic ld_command;
	logic ld_opa;
	logic ld_opb_hi;
	logic ld_opb_lo;
	logic emit;

	logic        out_valid_q;
	logic [7:0]  out_src_q;
	logic [6:0]  out_letter_q;
	logic [7:0]  out_opa_q;
	logic [15:0] out_opb_q;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			cmd_en_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_OWN_ID: own_id_q <= pwdata[7:0];
				REG_CMD_EN: cmd_en_q <= pwdata[CMD_EN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_OWN_ID: prdata = {24'd0, own_id_q};
			REG_CMD_EN: prdata = {{(32-CMD_EN_W){1'b0}}, cmd_en_q};
			default: prdata = '0;
		endcase
	end

	// Input register; a byte moves on when the result register can take it.
	assign advance  = valid_s1 && (!out_valid_q || cmd.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Next phase of the frame parser.
	always_comb begin
		phase_nxt = PH_HUNT;
		unique case (phase_q)
			PH_HUNT:   phase_nxt = (byte_s1 == HDR_A) ? PH_HDR_F : PH_HUNT;
			PH_HDR_F: begin
				if (byte_s1 == HDR_F) begin
					phase_nxt = PH_TARGET;
				end else if (byte_s1 == HDR_A) begin
					phase_nxt = PH_HDR_F;
				end else begin
					phase_nxt = PH_HUNT;
				end
			end
			PH_TARGET: phase_nxt = (byte_s1 == own_id_q || byte_s1 == BCAST) ?
				PH_SOURCE : PH_HUNT;
			PH_SOURCE: phase_nxt = PH_CMD;
			PH_CMD:    phase_nxt = PH_OPA;
			PH_OPA:    phase_nxt = PH_OPB_HI;
			PH_OPB_HI: phase_nxt = PH_OPB_LO;
			PH_OPB_LO: phase_nxt = PH_TRL_F;
			PH_TRL_F:  phase_nxt = (byte_s1 == HDR_F) ? PH_TRL_A : PH_HUNT;
			PH_TRL_A:  phase_nxt = PH_HUNT;
			default:   phase_nxt = PH_HUNT;
		endcase
	end

	// Field captures and result strobe for the current phase.
	always_comb begin
		ld_sender  = 1'b0;
		ld_command = 1'b0;
		ld_opa     = 1'b0;
		ld_opb_hi  = 1'b0;
		ld_opb_lo  = 1'b0;
		emit       = 1'b0;
		unique case (phase_q)
			PH_SOURCE: ld_sender  = 1'b1;
			PH_CMD:    ld_command = 1'b1;
			PH_OPA:    ld_opa     = 1'b1;
			PH_OPB_HI: ld_opb_hi  = 1'b1;
			PH_OPB_LO: ld_opb_lo  = 1'b1;
			PH_TRL_A:  emit = (byte_s1 == HDR_A) && letter_enabled(command_q, cmd_en_q);
			default: ;
		endcase
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			sender_q  <= 8'hFF;
			command_q <= 8'hFF;
			opa_q     <= 8'hFF;
			opb_q     <= 16'hFFFF;
		end else if (advance) begin
			phase_q <= phase_nxt;
			if (ld_sender) begin
				sender_q <= byte_s1;
			end
			if (ld_command) begin
				command_q <= byte_s1;
			end
			if (ld_opa) begin
				opa_q <= byte_s1;
			end
			if (ld_opb_hi) begin
				opb_q <= {byte_s1, 8'h00};
			end
			if (ld_opb_lo) begin
				opb_q <= {opb_q[15:8], byte_s1};
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_src_q    <= sender_q;
			out_letter_q <= command_q[6:0];
			out_opa_q    <= opa_q;
			out_opb_q    <= opb_q;
		end
	end

	assign cmd.valid          = out_valid_q;
	assign cmd.source_id      = out_src_q;
	assign cmd.command_letter = out_letter_q;
	assign cmd.operand_a      = out_opa_q;
	assign cmd.operand_b      = out_opb_q;

	// Checks on the parser.
	`SCFP_ASSERT_SAME(a_emit_on_trailer, advance && emit, phase_q == PH_TRL_A)
	`SCFP_ASSERT_NEXT(a_trailer_to_hunt, advance && phase_q == PH_TRL_A, phase_q == PH_HUNT)
	`SCFP_ASSERT_SAME(a_never_p, out_valid_q, out_letter_q != LETTER_P[6:0])

endmodule

`default_nettype wire

### test/serial_command_frame_parser_tb.sv
`timescale 1ns / 1ps

module serial_command_frame_parser_tb;
	import scfp_pkg::*;

	// Register byte addresses on the configuration port.
	localparam logic [PADDR_W-1:0] ADDR_OWN_ID = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_CMD_EN = 3'd4;

	// Cycles the parser may still be busy after the last result, and the
	// number of cycles without any traffic that counts as a hang.
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// Side index for the idle pattern generator.
	localparam int SIDE_RX  = 0;
	localparam int SIDE_CMD = 1;

	typedef struct packed {
		logic [7:0]  source_id;
		logic [6:0]  command_letter;
		logic [7:0]  operand_a;
		logic [15:0] operand_b;
	} cmd_item_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	wire  [31:0]        prdata;
	wire                pready;

	scfp_byte_if rx_ch();
	scfp_cmd_if  cmd_ch();

	serial_command_frame_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.cmd     (cmd_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bytes waiting to be sent and commands the parser still owes us.
	logic [7:0] byte_q[$];
	cmd_item_t  cmd_expect_q[$];

	// Shadow copy of the parser state and its registers.
	phase_t              parse_phase;
	logic [7:0]          sender_hold;
	logic [7:0]          command_hold;
	logic [7:0]          opa_hold;
	logic [15:0]         opb_hold;
	logic [7:0]          own_id_cfg;
	logic [CMD_EN_W-1:0] cmd_en_cfg;

	int unsigned calm_left[2];
	int unsigned tx_gap;
	int unsigned rx_stall;
	int unsigned bytes_queued;
	int unsigned bytes_sent;
	int unsigned frames_built;
	int unsigned cmds_predicted;
	int unsigned cmds_checked;
	int unsigned settings_used;
	int unsigned mismatches;
	int unsigned idle_cycles;

	// Length of the next idle stretch: mostly none or short, a few long, and
	// now and then a run of items with no idling at all.
	function automatic int unsigned pick_gap(input int side);
		int unsigned r;
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_left[side] = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Advance the shadow parser by one byte and queue any command it yields.
	function automatic void parse_byte(input logic [7:0] c);
		logic [7:0] offs;
		logic       deliver;
		case (parse_phase)
			PH_HUNT: parse_phase = (c == HDR_A) ? PH_HDR_F : PH_HUNT;
			PH_HDR_F: begin
				if (c == HDR_F)
					parse_phase = PH_TARGET;
				else if (c == HDR_A)
					parse_phase = PH_HDR_F;
				else
					parse_phase = PH_HUNT;
			end
			PH_TARGET: parse_phase = (c == own_id_cfg || c == BCAST) ? PH_SOURCE : PH_HUNT;
			PH_SOURCE: begin
				sender_hold = c;
				parse_phase = PH_CMD;
			end
			PH_CMD: begin
				command_hold = c;
				parse_phase = PH_OPA;
			end
			PH_OPA: begin
				opa_hold = c;
				parse_phase = PH_OPB_HI;
			end
			PH_OPB_HI: begin
				opb_hold = {c, 8'h00};
				parse_phase = PH_OPB_LO;
			end
			PH_OPB_LO: begin
				opb_hold[7:0] = c;
				parse_phase = PH_TRL_F;
			end
			PH_TRL_F: parse_phase = (c == HDR_F) ? PH_TRL_A : PH_HUNT;
			PH_TRL_A: begin
				// Only letters A to Z other than P, with their enable bit set.
				offs = command_hold - HDR_A;
				deliver = (c == HDR_A) && (command_hold >= HDR_A) &&
					(command_hold <= LETTER_Z) && (command_hold != LETTER_P) &&
					cmd_en_cfg[offs[4:0]];
				if (deliver) begin
					cmd_expect_q.push_back({sender_hold, command_hold[6:0], opa_hold, opb_hold});
					cmds_predicted++;
				end
				parse_phase = PH_HUNT;
			end
			default: parse_phase = PH_HUNT;
		endcase
	endfunction

	function automatic void report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Byte driver: holds each item until the parser takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= 8'h00;
			tx_gap = 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				parse_byte(rx_ch.rx_byte);
				void'(byte_q.pop_front());
				bytes_sent++;
				tx_gap = pick_gap(SIDE_RX);
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					rx_ch.valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= byte_q[0];
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Command monitor: checks each item against the oldest prediction and
	// stalls the channel at random.
	always @(posedge clk or negedge arst_n) begin : cmd_monitor
		cmd_item_t want;
		if (!arst_n) begin
			cmd_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (cmd_expect_q.size() == 0) begin
					$display("%0t: unexpected command item, got src %h letter %h a %h b %h",
						$time, cmd_ch.source_id, cmd_ch.command_letter,
						cmd_ch.operand_a, cmd_ch.operand_b);
					mismatches++;
				end else begin
					want = cmd_expect_q.pop_front();
					report_field("source_id", 16'(want.source_id), 16'(cmd_ch.source_id));
					report_field("command_letter", 16'(want.command_letter),
						16'(cmd_ch.command_letter));
					report_field("operand_a", 16'(want.operand_a), 16'(cmd_ch.operand_a));
					report_field("operand_b", want.operand_b, cmd_ch.operand_b);
				end
				cmds_checked++;
				rx_stall = pick_gap(SIDE_CMD);
			end else if (!cmd_ch.valid && cmd_ch.ready && $urandom_range(0, 15) == 0) begin
				rx_stall = pick_gap(SIDE_CMD);
			end
			if (rx_stall != 0) begin
				rx_stall--;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= 1'b1;
			end
		end
	end

	// Hang detection: any cycle with traffic on a channel or the register
	// port restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no traffic for %0d cycles, %0d commands still owed",
					$time, WATCHDOG_LIMIT, cmd_expect_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_OWN_ID: own_id_cfg = data[7:0];
			ADDR_CMD_EN: cmd_en_cfg = data[CMD_EN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b);
		byte_q.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_frame(input int unsigned n_hdr_a, input logic [7:0] target,
			input logic [7:0] src, input logic [7:0] letter, input logic [7:0] opa,
			input logic [15:0] opb, input logic [7:0] trl_f, input logic [7:0] trl_a);
		repeat (n_hdr_a) queue_byte(HDR_A);
		queue_byte(HDR_F);
		queue_byte(target);
		queue_byte(src);
		queue_byte(letter);
		queue_byte(opa);
		queue_byte(opb[15:8]);
		queue_byte(opb[7:0]);
		queue_byte(trl_f);
		queue_byte(trl_a);
		frames_built++;
	endtask

	function automatic logic [7:0] pick_operand();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed frames with random content, some addressed elsewhere,
	// some with bad letters or trailers, some preceded by line noise.
	task automatic push_random_frame();
		int unsigned r;
		logic [7:0]  target;
		logic [7:0]  letter;
		logic [7:0]  trl_f;
		logic [7:0]  trl_a;
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
		r = $urandom_range(0, 99);
		if (r < 55)
			target = own_id_cfg;
		else if (r < 80)
			target = BCAST;
		else
			target = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 80)
			letter = HDR_A + 8'($urandom_range(0, 25));
		else if (r < 90)
			letter = LETTER_P;
		else
			letter = 8'($urandom_range(0, 255));
		trl_f = HDR_F;
		trl_a = HDR_A;
		r = $urandom_range(0, 99);
		if (r < 5)
			trl_f = 8'($urandom_range(0, 255));
		else if (r < 10)
			trl_a = 8'($urandom_range(0, 255));
		push_frame($urandom_range(1, 3), target, 8'($urandom_range(0, 255)), letter,
			pick_operand(), {pick_operand(), pick_operand()}, trl_f, trl_a);
	endtask

	// Wait until every byte is taken and every command has arrived, then let
	// the pipeline settle so a register write finds the parser idle.
	task automatic drain();
		while (byte_q.size() != 0 || rx_ch.valid || cmd_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] own_w, input logic [31:0] en_w,
			input int unsigned n_bytes, input int unsigned min_cmds, input bit directed);
		int unsigned start;
		write_reg(ADDR_OWN_ID, own_w);
		write_reg(ADDR_CMD_EN, en_w);
		settings_used++;
		start = bytes_queued;
		if (directed) begin
			// Broadcast with a repeated header and all-zero fields, then a
			// frame to this node with all-ones fields.
			push_frame(2, BCAST, 8'h00, LETTER_Z, 8'h00, 16'h0000, HDR_F, HDR_A);
			push_frame(1, own_id_cfg, 8'hFF, HDR_A, 8'hFF, 16'hFFFF, HDR_F, HDR_A);
		end
		while (bytes_queued - start < n_bytes || cmds_predicted < min_cmds) begin
			while (byte_q.size() > 32)
				@(posedge clk);
			push_random_frame();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cmd_ch.ready = 1'b0;
		parse_phase = PH_HUNT;
		sender_hold = 8'hFF;
		command_hold = 8'hFF;
		opa_hold = 8'hFF;
		opb_hold = 16'hFFFF;
		own_id_cfg = 8'h00;
		cmd_en_cfg = '0;
		calm_left[SIDE_RX] = 0;
		calm_left[SIDE_CMD] = 0;
		bytes_queued = 0;
		bytes_sent = 0;
		frames_built = 0;
		cmds_predicted = 0;
		cmds_checked = 0;
		settings_used = 0;
		mismatches = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings run from all letters on (the P bit included) to none, with
		// own ids at both ends and equal to the broadcast byte. High bits
		// beyond each register's width are written and must be dropped.
		run_phase(32'hA5C3_005C, 32'hFFFF_FFFF, 200, 0, 1'b1);
		run_phase(32'h0000_0000, 32'h0000_0000, 80, 0, 1'b0);
		run_phase(32'hFFFF_FFFF, $urandom, 180, 0, 1'b0);
		run_phase(32'h0000_0030, 32'h02AA_AAAA, 160, 0, 1'b0);
		run_phase($urandom, 32'h03FF_FFFF, 180, 48, 1'b0);

		$display("Sent %0d bytes in %0d frames under %0d register settings.",
			bytes_sent, frames_built, settings_used);
		$display("Checked %0d command items, %0d mismatches.", cmds_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/scfp_pkg.sv
hdl/scfp_channels.sv
hdl/serial_command_frame_parser.sv
test/serial_command_frame_parser_tb.sv
